@@ rtl/pst_pkg.sv @@
// pst_pkg: shared types and codes for the pe section address translator
// query and result transaction structs, mode and status codes, register indexes
// no dependencies
package pst_pkg;

    localparam int MAX_SECTIONS_DEF = 16;

    localparam logic [1:0] MODE_LOAD    = 2'd0;
    localparam logic [1:0] MODE_TO_FILE = 2'd1;
    localparam logic [1:0] MODE_TO_VIRT = 2'd2;

    localparam logic [1:0] STATUS_TRANSLATED = 2'd0;
    localparam logic [1:0] STATUS_HEADER     = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND  = 2'd2;
    localparam logic [1:0] STATUS_LOADED     = 2'd3;

    localparam logic [1:0] REG_HEADER_SIZE   = 2'd0;
    localparam logic [1:0] REG_SECTION_COUNT = 2'd1;

    typedef struct packed {
        logic [1:0]  mode;
        logic [3:0]  entry_index;
        logic [31:0] entry_virtual_start;
        logic [31:0] entry_span;
        logic [31:0] entry_file_start;
        logic [31:0] query_address;
    } query_t;

    typedef struct packed {
        logic [31:0] translated_address;
        logic [1:0]  status;
    } result_t;

endpackage

@@ rtl/pe_section_address_translate_core.sv @@
// pe_section_address_translate_core: section table and sequential address translator
// one shared range-compare unit walks the section table under a small sequencer
// depends on pst_pkg
//
//  channel  | signals                                  | direction | handshake
//  ---------+------------------------------------------+-----------+-------------------
//  query    | query_valid, query_stall, query          | in        | valid && !stall
//  result   | result_valid, result_stall, result       | out       | valid && !stall
//  cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data| in        | valid && ready
//
// a load, a header passthrough or an unused mode goes from idle straight to finish; a walk
// runs scan, then calc on a hit, then finish, and searches n = min(section_count,
// MAX_SECTIONS) entries with the single compare unit reading one table entry a cycle;
// a new query can be accepted in the cycle the result is first offered
// query_stall is high from accept until the result is placed in the output register
// result_stall holds the output register and the sequencer waits in its last step
// rst_n clears control, config registers and output valid; table and data registers have no reset
module pe_section_address_translate_core #(
    parameter int MAX_SECTIONS = pst_pkg::MAX_SECTIONS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             query_valid,
    output logic             query_stall,
    input  pst_pkg::query_t  query,
    output logic             result_valid,
    input  logic             result_stall,
    output pst_pkg::result_t result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [31:0]      cfg_data
);
    import pst_pkg::*;

    // table address width and count width (count holds MAX_SECTIONS itself)
    localparam int AW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int CW = $clog2(MAX_SECTIONS + 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_CALC   = 3'd2;
    localparam logic [2:0] ST_FINISH = 3'd3;

    // section table memories
    logic [31:0] virt_mem [MAX_SECTIONS];
    logic [31:0] span_mem [MAX_SECTIONS];
    logic [31:0] file_mem [MAX_SECTIONS];

    logic [31:0] header_size_reg;
    logic [4:0]  section_count_reg;

    logic [2:0]  state_reg, state_next;
    logic [1:0]  mode_reg, mode_next;
    logic [31:0] addr_reg, addr_next;
    logic [CW-1:0] issue_reg, issue_next;
    logic [CW-1:0] lim_reg, lim_next;
    logic        pend_reg, pend_next;
    logic [31:0] base_reg, base_next;
    logic [31:0] other_reg, other_next;
    logic [31:0] res_addr_reg, res_addr_next;
    logic [1:0]  res_status_reg, res_status_next;

    logic [31:0] rd_virt_reg, rd_span_reg, rd_file_reg;

    logic        out_valid_reg;
    result_t     out_reg;

    logic        q_accept;
    logic        load_wr;
    logic [AW+3:0] wr_addr_wide;
    logic [AW-1:0] wr_addr;
    logic        rd_en;
    logic [AW-1:0] rd_addr;
    logic [31:0] lim_wide;
    logic        out_load;

    // shared range-compare unit
    logic [31:0] sel_base, sel_other, range_hi;
    logic        hit;

    assign cfg_ready   = 1'b1;
    assign query_stall = (state_reg != ST_IDLE);
    assign q_accept    = query_valid && !query_stall;

    assign wr_addr_wide = {{AW{1'b0}}, query.entry_index};
    assign wr_addr      = wr_addr_wide[AW-1:0];
    assign load_wr      = q_accept && (query.mode == MODE_LOAD)
                          && (32'(query.entry_index) < 32'(MAX_SECTIONS));

    assign lim_wide = (32'(section_count_reg) > 32'(MAX_SECTIONS))
                      ? 32'(MAX_SECTIONS) : 32'(section_count_reg);

    assign rd_en   = (state_reg == ST_SCAN) && (issue_reg < lim_reg) && !hit;
    assign rd_addr = issue_reg[AW-1:0];

    // base is the space the query address lives in
    assign sel_base  = (mode_reg == MODE_TO_FILE) ? rd_virt_reg : rd_file_reg;
    assign sel_other = (mode_reg == MODE_TO_FILE) ? rd_file_reg : rd_virt_reg;
    assign range_hi  = sel_base + rd_span_reg;
    assign hit       = pend_reg && (addr_reg >= sel_base) && (addr_reg < range_hi);

    assign out_load = (state_reg == ST_FINISH) && (!out_valid_reg || !result_stall);

    // table write on load, registered read during the walk
    always_ff @(posedge clk)
    begin
        if (load_wr)
        begin
            virt_mem[wr_addr] <= query.entry_virtual_start;
            span_mem[wr_addr] <= query.entry_span;
            file_mem[wr_addr] <= query.entry_file_start;
        end
        if (rd_en)
        begin
            rd_virt_reg <= virt_mem[rd_addr];
            rd_span_reg <= span_mem[rd_addr];
            rd_file_reg <= file_mem[rd_addr];
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_size_reg   <= '0;
            section_count_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_HEADER_SIZE:   header_size_reg   <= cfg_data;
                REG_SECTION_COUNT: section_count_reg <= cfg_data[4:0];
                default:           ;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        addr_next       = addr_reg;
        issue_next      = issue_reg;
        lim_next        = lim_reg;
        pend_next       = pend_reg;
        base_next       = base_reg;
        other_next      = other_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_accept)
                begin
                    mode_next     = query.mode;
                    addr_next     = query.query_address;
                    issue_next    = '0;
                    pend_next     = 1'b0;
                    lim_next      = lim_wide[CW-1:0];
                    res_addr_next = '0;
                    if (query.mode == MODE_LOAD)
                    begin
                        res_status_next = STATUS_LOADED;
                        state_next      = ST_FINISH;
                    end
                    else if (query.mode == MODE_TO_FILE || query.mode == MODE_TO_VIRT)
                    begin
                        if (query.query_address < header_size_reg)
                        begin
                            res_addr_next   = query.query_address;
                            res_status_next = STATUS_HEADER;
                            state_next      = ST_FINISH;
                        end
                        else
                        begin
                            res_status_next = STATUS_NOT_FOUND;
                            state_next      = ST_SCAN;
                        end
                    end
                    else
                    begin
                        // unused mode answers not found
                        res_status_next = STATUS_NOT_FOUND;
                        state_next      = ST_FINISH;
                    end
                end
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    base_next  = sel_base;
                    other_next = sel_other;
                    pend_next  = 1'b0;
                    state_next = ST_CALC;
                end
                else if (rd_en)
                begin
                    issue_next = issue_reg + CW'(1);
                    pend_next  = 1'b1;
                end
                else
                begin
                    // table exhausted, last entry checked
                    pend_next  = 1'b0;
                    state_next = ST_FINISH;
                end
            end
            ST_CALC:
            begin
                res_addr_next   = addr_reg - base_reg + other_reg;
                res_status_next = STATUS_TRANSLATED;
                state_next      = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            issue_reg <= '0;
            lim_reg   <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            issue_reg <= issue_next;
            lim_reg   <= lim_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        addr_reg       <= addr_next;
        base_reg       <= base_next;
        other_reg      <= other_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
    end

    // output register parts the sequencer from the result consumer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg.translated_address <= res_addr_reg;
            out_reg.status             <= res_status_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // walk never reads past the searched count
    a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (issue_reg <= lim_reg))
        else $error("section walk ran past the search limit");

    // not-found and loaded results carry a zero address
    a_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.status == STATUS_NOT_FOUND
                          || result.status == STATUS_LOADED))
        |-> (result.translated_address == 32'd0))
        else $error("nonzero address on a not-found or load result");

    // an accepted transaction always leaves idle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        q_accept |=> (state_reg != ST_IDLE))
        else $error("sequencer stayed idle after a query transaction");

endmodule
